@@ hw/rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/avws_pkg.sv @@
package avws_pkg;

  // fixed field widths
  localparam int IN_LANES    = 8;
  localparam int WEIGHT_W    = 16;
  localparam int VALUE_W     = 16;
  localparam int PROD_W      = WEIGHT_W + VALUE_W;
  localparam int ACC_W       = 48;
  localparam int RES_W       = 32;
  localparam int SHIFT_W     = 5;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(15);

  // value chunk as seen on the input ports
  typedef logic [IN_LANES-1:0][VALUE_W-1:0] avws_vals_t;

  // result chunk as driven on the output ports
  typedef logic [IN_LANES-1:0][RES_W-1:0] avws_res_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [IN_LANES-1:0][PROD_W-1:0] prod;
    logic [IN_LANES-1:0]             lane_en;
    logic                            final_row;
    logic                            last_chunk;
  } avws_item_t;

endpackage

@@ hw/rtl/avws_front.sv @@
module avws_front #(
  parameter int VECTOR_LENGTH = 128,
  parameter int LANES         = 8,
  localparam int CHUNKS = ((VECTOR_LENGTH / LANES) > 0) ? (VECTOR_LENGTH / LANES) : 1,
  localparam int ROW_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [avws_pkg::WEIGHT_W-1:0]     weight_i,
  input  avws_pkg::avws_vals_t                     values_i,
  input  logic                                     final_row_i,
  input  logic                                     q_ready_i,
  input  logic                                     clr_busy_i,
  output logic                                     push_o,
  output avws_pkg::avws_item_t                     item_o,
  output logic [ROW_W-1:0]                         row_o
);
  import avws_pkg::*;

  localparam int UL = (LANES < IN_LANES) ? LANES : IN_LANES;

  logic [ROW_W-1:0]        pos_q, pos_d;
  logic                    last_pos;
  logic signed [PROD_W-1:0] prod [IN_LANES];
  logic [IN_LANES-1:0]     lane_en;

  // take an item whenever the queue has room and the clear pass is done
  assign in_stall_o = !q_ready_i || clr_busy_i;
  assign push_o     = in_valid_i && !in_stall_o;
  assign last_pos   = (pos_q == ROW_W'(CHUNKS - 1));

  // per-lane multiply and lane qualification
  for (genvar j = 0; j < IN_LANES; j++) begin : g_lane
    assign prod[j]    = weight_i * $signed(values_i[j]);
    assign lane_en[j] = (j < UL) && ((int'(pos_q) * LANES + j) < VECTOR_LENGTH);
    assign item_o.prod[j] = prod[j];
  end

  assign item_o.lane_en    = lane_en;
  assign item_o.final_row  = final_row_i;
  assign item_o.last_chunk = last_pos;
  assign row_o             = pos_q;

  // chunk position, wraps after the last chunk of a row
  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      pos_d = last_pos ? '0 : pos_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

@@ hw/rtl/avws_queue.sv @@
module avws_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         ready_o,
  output logic         valid_o,
  output logic [W-1:0] data_o,
  input  logic         pop_i
);

  logic [W-1:0]  store_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign ready_o = (count_q != CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = store_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/avws_back.sv @@
module avws_back #(
  parameter int VECTOR_LENGTH = 128,
  parameter int LANES         = 8,
  localparam int CHUNKS = ((VECTOR_LENGTH / LANES) > 0) ? (VECTOR_LENGTH / LANES) : 1,
  localparam int ROW_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [avws_pkg::SHIFT_W-1:0]       shift_i,
  input  logic                               q_valid_i,
  input  avws_pkg::avws_item_t               item_i,
  input  logic [ROW_W-1:0]                   row_i,
  output logic                               pop_o,
  output logic                               clr_busy_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output avws_pkg::avws_res_t                res_o,
  output logic                               last_o
);
  import avws_pkg::*;

  localparam int UL = (LANES < IN_LANES) ? LANES : IN_LANES;

  typedef logic [UL-1:0][ACC_W-1:0] row_t;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  // accumulator rows, one per chunk position
  row_t acc_mem [CHUNKS];
  row_t rd_q;

  // clear pass after reset
  logic             clr_busy_q;
  logic [ROW_W-1:0] clr_row_q;

  // stage 1: row read in flight
  logic             s1_valid_q;
  avws_item_t       s1_item_q;
  logic [ROW_W-1:0] s1_row_q;

  // last written row, for a read that raced its write
  logic             wb_valid_q;
  logic [ROW_W-1:0] wb_row_q;
  row_t             wb_data_q;

  // stage 2: updated sums
  logic                s2_valid_q;
  logic                s2_final_q;
  logic                s2_last_q;
  logic [IN_LANES-1:0] s2_en_q;
  row_t                s2_sum_q;

  // output register
  logic      out_valid_q;
  avws_res_t out_res_q;
  logic      out_last_q;

  logic      adv;
  row_t      acc_row;
  row_t      sum_row;
  row_t      wr_row;
  avws_res_t res_d;

  logic signed [ACC_W:0]   sum_ext [UL];
  logic signed [ACC_W-1:0] sh_val  [UL];

  // whole back pipeline moves unless a result waits on a stalled receiver
  assign adv        = !out_valid_q || !out_stall_i;
  assign pop_o      = q_valid_i && adv && !clr_busy_q;
  assign clr_busy_o = clr_busy_q;
  assign acc_row    = (wb_valid_q && (wb_row_q == s1_row_q)) ? wb_data_q : rd_q;

  for (genvar j = 0; j < IN_LANES; j++) begin : g_lane
    if (j < UL) begin : g_used
      // saturating accumulate of the lane product
      assign sum_ext[j] = $signed({acc_row[j][ACC_W-1], acc_row[j]}) +
                          $signed({{(ACC_W + 1 - PROD_W){s1_item_q.prod[j][PROD_W-1]}},
                                   s1_item_q.prod[j]});
      always_comb begin
        sum_row[j] = acc_row[j];
        if (s1_item_q.lane_en[j]) begin
          if (sum_ext[j][ACC_W] != sum_ext[j][ACC_W-1]) begin
            sum_row[j] = sum_ext[j][ACC_W] ? ACC_MIN : ACC_MAX;
          end else begin
            sum_row[j] = sum_ext[j][ACC_W-1:0];
          end
        end
        wr_row[j] = (s1_item_q.lane_en[j] && s1_item_q.final_row) ? '0 : sum_row[j];
      end

      // arithmetic shift and 32-bit saturation
      assign sh_val[j] = $signed(s2_sum_q[j]) >>> shift_i;
      always_comb begin
        if (!s2_en_q[j]) begin
          res_d[j] = '0;
        end else if ((&sh_val[j][ACC_W-1:RES_W-1]) || !(|sh_val[j][ACC_W-1:RES_W-1])) begin
          res_d[j] = sh_val[j][RES_W-1:0];
        end else begin
          res_d[j] = sh_val[j][ACC_W-1] ? RES_MIN : RES_MAX;
        end
      end
    end else begin : g_unused
      assign res_d[j] = '0;
    end
  end

  // accumulator memory: clear sweep or write-back, registered read
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      acc_mem[clr_row_q] <= '0;
    end else if (adv && s1_valid_q) begin
      acc_mem[s1_row_q] <= wr_row;
    end
    if (pop_o) begin
      rd_q <= acc_mem[row_i];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_row_q   <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wb_valid_q  <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        if (clr_row_q == ROW_W'(CHUNKS - 1)) begin
          clr_busy_q <= 1'b0;
        end else begin
          clr_row_q <= clr_row_q + ROW_W'(1);
        end
      end
      if (adv) begin
        s1_valid_q  <= pop_o;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q && s2_final_q;
        if (s1_valid_q) begin
          wb_valid_q <= 1'b1;
        end
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_item_q <= item_i;
      s1_row_q  <= row_i;
    end
    if (adv) begin
      s2_final_q <= s1_item_q.final_row;
      s2_last_q  <= s1_item_q.last_chunk;
      s2_en_q    <= s1_item_q.lane_en;
      s2_sum_q   <= sum_row;
      out_res_q  <= res_d;
      out_last_q <= s2_last_q;
      if (s1_valid_q) begin
        wb_row_q  <= s1_row_q;
        wb_data_q <= wr_row;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_res_q;
  assign last_o      = out_last_q;

endmodule

@@ hw/rtl/attention_value_weighted_sum_core.sv @@
// attention value weighted sum core
// input channel: one transfer per chunk, carrying the row weight (Q1.15), eight
// value elements (Q8.8) and final_row. chunks arrive in row order,
// VECTOR_LENGTH/LANES chunks per row; an internal position counter tracks them.
// each lane multiplies and adds into a 48-bit saturating accumulator.
// output channel: a chunk of the final row produces one transfer with eight
// 32-bit results (shifted right by result_shift, then saturated) and
// last_chunk set on the last chunk of the vector; other chunks produce nothing.
// throughput: one chunk per cycle unless out_stall_i or the clear pass holds it,
// set by the accumulator memory with one read port and one write port; a chunk
// passes the queue, row read, sum stage and output register before out_valid_o.
// reset: accumulators are cleared by a sweep over the VECTOR_LENGTH/LANES rows
// (16 at the defaults) while in_stall_o stays high; result_shift resets to 15.
// when out_stall_i holds a result, the back pipeline holds and a 4-entry queue
// keeps taking input until it fills, then in_stall_o rises. The user writes
// result_shift via cfg_we_i / cfg_wdata_i only while the core is idle; the core does not check.
module attention_value_weighted_sum_core #(
  parameter int VECTOR_LENGTH = 128,
  parameter int LANES         = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [avws_pkg::SHIFT_W-1:0]          cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [avws_pkg::WEIGHT_W-1:0]  weight_i,
  input  logic signed [avws_pkg::VALUE_W-1:0]   value_lane_0_i,
  input  logic signed [avws_pkg::VALUE_W-1:0]   value_lane_1_i,
  input  logic signed [avws_pkg::VALUE_W-1:0]   value_lane_2_i,
  input  logic signed [avws_pkg::VALUE_W-1:0]   value_lane_3_i,
  input  logic signed [avws_pkg::VALUE_W-1:0]   value_lane_4_i,
  input  logic signed [avws_pkg::VALUE_W-1:0]   value_lane_5_i,
  input  logic signed [avws_pkg::VALUE_W-1:0]   value_lane_6_i,
  input  logic signed [avws_pkg::VALUE_W-1:0]   value_lane_7_i,
  input  logic                                  final_row_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [avws_pkg::RES_W-1:0]     result_lane_0_o,
  output logic signed [avws_pkg::RES_W-1:0]     result_lane_1_o,
  output logic signed [avws_pkg::RES_W-1:0]     result_lane_2_o,
  output logic signed [avws_pkg::RES_W-1:0]     result_lane_3_o,
  output logic signed [avws_pkg::RES_W-1:0]     result_lane_4_o,
  output logic signed [avws_pkg::RES_W-1:0]     result_lane_5_o,
  output logic signed [avws_pkg::RES_W-1:0]     result_lane_6_o,
  output logic signed [avws_pkg::RES_W-1:0]     result_lane_7_o,
  output logic                                  last_chunk_o
);
  import avws_pkg::*;

  localparam int CHUNKS = ((VECTOR_LENGTH / LANES) > 0) ? (VECTOR_LENGTH / LANES) : 1;
  localparam int ROW_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int QW     = ROW_W + $bits(avws_item_t);

  logic [SHIFT_W-1:0] shift_q;
  avws_vals_t         values;
  avws_res_t          res;

  logic             q_ready;
  logic             q_valid;
  logic             push;
  logic             pop;
  logic             clr_busy;
  avws_item_t       f_item;
  logic [ROW_W-1:0] f_row;
  avws_item_t       b_item;
  logic [ROW_W-1:0] b_row;
  logic [QW-1:0]    q_out;

  // shift register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SHIFT_RESET;
    end else if (cfg_we_i) begin
      shift_q <= cfg_wdata_i;
    end
  end

  // gather input lanes
  assign values[0] = value_lane_0_i;
  assign values[1] = value_lane_1_i;
  assign values[2] = value_lane_2_i;
  assign values[3] = value_lane_3_i;
  assign values[4] = value_lane_4_i;
  assign values[5] = value_lane_5_i;
  assign values[6] = value_lane_6_i;
  assign values[7] = value_lane_7_i;

  avws_front #(
    .VECTOR_LENGTH (VECTOR_LENGTH),
    .LANES         (LANES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .weight_i    (weight_i),
    .values_i    (values),
    .final_row_i (final_row_i),
    .q_ready_i   (q_ready),
    .clr_busy_i  (clr_busy),
    .push_o      (push),
    .item_o      (f_item),
    .row_o       (f_row)
  );

  avws_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_row, f_item}),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_out),
    .pop_i   (pop)
  );

  assign {b_row, b_item} = q_out;

  avws_back #(
    .VECTOR_LENGTH (VECTOR_LENGTH),
    .LANES         (LANES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (shift_q),
    .q_valid_i   (q_valid),
    .item_i      (b_item),
    .row_i       (b_row),
    .pop_o       (pop),
    .clr_busy_o  (clr_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res),
    .last_o      (last_chunk_o)
  );

  // spread result lanes onto the ports
  assign result_lane_0_o = res[0];
  assign result_lane_1_o = res[1];
  assign result_lane_2_o = res[2];
  assign result_lane_3_o = res[3];
  assign result_lane_4_o = res[4];
  assign result_lane_5_o = res[5];
  assign result_lane_6_o = res[6];
  assign result_lane_7_o = res[7];

endmodule

@@ hw/rtl/avws_checker.sv @@
`include "assert_macros.svh"

module avws_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_we_i,
  input logic [avws_pkg::SHIFT_W-1:0]      cfg_wdata_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [avws_pkg::RES_W-1:0] result_lane_0_o,
  input logic                              last_chunk_o
);
  import avws_pkg::*;

  localparam int                 MAX_SHIFT = (1 << SHIFT_W) - 1;
  localparam int                 TOP_BIT   = ACC_W - 1 - MAX_SHIFT;
  localparam logic [SHIFT_W-1:0] SHIFT_ALL = SHIFT_W'(MAX_SHIFT);

  logic [SHIFT_W-1:0] shift_seen_q;

  // shadow of the shift register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_seen_q <= SHIFT_RESET;
    end else if (cfg_we_i) begin
      shift_seen_q <= cfg_wdata_i;
    end
  end

  // a held result stays presented
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // a held result keeps its lane 0 payload and last_chunk flag
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(result_lane_0_o) && $stable(last_chunk_o), "result changed while stalled")

  // input is held off right after reset, as the accumulator clear pass begins
  `ASSERT_ALWAYS(a_clear_stall, clk_i, rst_ni, (!$past(rst_ni)) |-> in_stall_o, "input taken during clear pass")

  // at the largest shift a 48-bit sum cannot reach the saturation limits
  `ASSERT_ALWAYS(a_shift_range, clk_i, rst_ni, (out_valid_o && (shift_seen_q == SHIFT_ALL)) |-> ((&result_lane_0_o[RES_W-1:TOP_BIT]) || !(|result_lane_0_o[RES_W-1:TOP_BIT])), "result out of range for full shift")

endmodule

bind attention_value_weighted_sum_core avws_checker u_avws_checker (.*);

@@ tb/tb_attention_value_weighted_sum_core.sv @@
`timescale 1ns / 100ps

module tb_attention_value_weighted_sum_core;
  import avws_pkg::*;

  localparam int VECTOR_LENGTH = 128;
  localparam int LANES         = 8;
  localparam int CHUNKS        = VECTOR_LENGTH / LANES;
  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 3;
  localparam int DRAIN_CYCLES  = 16;
  localparam int HOLD_CYCLES   = 60;
  localparam int PHASE_ITEMS   = 112;
  localparam int MAX_REPORTS   = 50;
  localparam longint TIMEOUT_NS = 2_000_000;
  localparam longint ACC_HI    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO    = -ACC_HI - 1;
  localparam longint RES_HI    = 64'sh0000_0000_7FFF_FFFF;
  localparam longint RES_LO    = -RES_HI - 1;

  // one input transfer: row weight, value chunk, final row mark
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    avws_vals_t          vals;
    logic                final_row;
  } chunk_t;

  // one output transfer
  typedef struct packed {
    avws_res_t lanes;
    logic      last;
  } chunk_sums_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [SHIFT_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall_o;
  chunk_t             drv_chunk = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic [RES_W-1:0]   result_lane_o [IN_LANES];
  logic               last_chunk_o;

  // predictor state
  logic signed [ACC_W-1:0] acc_image [VECTOR_LENGTH];
  int unsigned             chunk_pos = 0;
  logic [SHIFT_W-1:0]      shift_amt = SHIFT_RESET;

  chunk_t      pending_chunks [$];
  chunk_sums_t expected_sums [$];
  int unsigned chunks_queued = 0;
  int unsigned chunks_accepted = 0;
  int unsigned gen_pos = 0;
  int unsigned phase_count = 0;
  int unsigned report_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  bit          pressure_armed = 1'b0;
  bit          pressure_done = 1'b0;
  bit          failed = 1'b0;

  always #(CLK_HALF) clk = ~clk;

  attention_value_weighted_sum_core #(
    .VECTOR_LENGTH(VECTOR_LENGTH),
    .LANES        (LANES)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .weight_i       (drv_chunk.weight),
    .value_lane_0_i (drv_chunk.vals[0]),
    .value_lane_1_i (drv_chunk.vals[1]),
    .value_lane_2_i (drv_chunk.vals[2]),
    .value_lane_3_i (drv_chunk.vals[3]),
    .value_lane_4_i (drv_chunk.vals[4]),
    .value_lane_5_i (drv_chunk.vals[5]),
    .value_lane_6_i (drv_chunk.vals[6]),
    .value_lane_7_i (drv_chunk.vals[7]),
    .final_row_i    (drv_chunk.final_row),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .result_lane_0_o(result_lane_o[0]),
    .result_lane_1_o(result_lane_o[1]),
    .result_lane_2_o(result_lane_o[2]),
    .result_lane_3_o(result_lane_o[3]),
    .result_lane_4_o(result_lane_o[4]),
    .result_lane_5_o(result_lane_o[5]),
    .result_lane_6_o(result_lane_o[6]),
    .result_lane_7_o(result_lane_o[7]),
    .last_chunk_o   (last_chunk_o)
  );

  // multiply-accumulate one chunk into the shadow accumulators
  function automatic void accumulate_chunk(input chunk_t c);
    chunk_sums_t sums;
    longint      acc_sum;
    longint      scaled;
    int unsigned slot;
    sums = '0;
    for (int j = 0; j < LANES; j++) begin
      slot = chunk_pos * LANES + j;
      acc_sum = longint'(acc_image[slot]) +
                longint'($signed(c.weight)) * longint'($signed(c.vals[j]));
      if (acc_sum > ACC_HI) acc_sum = ACC_HI;
      if (acc_sum < ACC_LO) acc_sum = ACC_LO;
      if (c.final_row) begin
        scaled = acc_sum >>> shift_amt;
        if (scaled > RES_HI) scaled = RES_HI;
        if (scaled < RES_LO) scaled = RES_LO;
        sums.lanes[j] = scaled[RES_W-1:0];
        acc_image[slot] = '0;
      end else begin
        acc_image[slot] = acc_sum[ACC_W-1:0];
      end
    end
    sums.last = (chunk_pos == CHUNKS - 1);
    chunk_pos = (chunk_pos == CHUNKS - 1) ? 0 : chunk_pos + 1;
    if (c.final_row) expected_sums.push_back(sums);
  endfunction

  // random 16-bit word biased toward the extremes
  function automatic logic [15:0] rand_word();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic void push_chunk(input logic [15:0] w, input avws_vals_t v,
                                     input logic fin);
    chunk_t c;
    c.weight = w;
    c.vals = v;
    c.final_row = fin;
    pending_chunks.push_back(c);
    chunks_queued++;
    phase_count++;
    gen_pos = (gen_pos + 1) % CHUNKS;
  endfunction

  function automatic avws_vals_t rand_vals();
    avws_vals_t v;
    for (int j = 0; j < IN_LANES; j++) v[j] = rand_word();
    return v;
  endfunction

  // stray chunks with random final marks
  function automatic void queue_noise(input int n);
    for (int i = 0; i < n; i++) push_chunk(rand_word(), rand_vals(), 1'($urandom_range(1)));
  endfunction

  // aligned vector: rows of weighted chunks, the last row final
  function automatic void queue_vector(input int rows);
    logic [15:0] w;
    while (gen_pos != 0) push_chunk(rand_word(), rand_vals(), 1'b0);
    for (int r = 0; r < rows; r++) begin
      w = rand_word();
      for (int k = 0; k < CHUNKS; k++) push_chunk(w, rand_vals(), r == rows - 1);
    end
  endfunction

  function automatic void queue_phase(input int n);
    phase_count = 0;
    while (phase_count < n) begin
      if ($urandom_range(7) == 0) queue_noise($urandom_range(1, 20));
      else if ($urandom_range(3) == 0) queue_vector($urandom_range(4, 6));
      else queue_vector($urandom_range(1, 3));
    end
  endfunction

  // extreme values; first half of row accumulates, rest and next half are final
  function automatic void queue_directed();
    logic [15:0] ext [8];
    avws_vals_t  v;
    ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'h8000};
    for (int i = 0; i < 24; i++) begin
      for (int j = 0; j < IN_LANES; j++) v[j] = ext[(i + j) % 8];
      push_chunk(i >= 8 && i < 16 ? 16'h7FFF : 16'h8000, v, i >= 8);
    end
  endfunction

  task automatic wait_drained();
    while (chunks_accepted != chunks_queued || expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_shift(input logic [SHIFT_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shift_amt = v;
  endtask

  function automatic void report_mismatch(input string what, input longint want,
                                          input longint got);
    failed = 1'b1;
    if (report_count < MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected %0d got %0d", $time, what, want, got);
    report_count++;
  endfunction

  // input driver: hold payload until transfer, then maybe idle
  always @(posedge clk) begin : driver
    if (rst_n) begin
      if (in_valid && !in_stall_o) begin
        accumulate_chunk(drv_chunk);
        chunks_accepted++;
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_chunks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_chunk <= pending_chunks.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off to back up the core
  always @(posedge clk) begin : receiver
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (pressure_armed && !pressure_done && out_valid_o) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      pressure_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // output monitor: compare each transfer with the oldest expected sums
  always @(posedge clk) begin : monitor
    chunk_sums_t want;
    if (rst_n && out_valid_o === 1'b1 && !out_stall) begin
      if (expected_sums.size() == 0) begin
        failed = 1'b1;
        if (report_count < MAX_REPORTS)
          $display("%0t ns: result transfer mismatch, expected none got lane 0 %0d",
                   $time, $signed(result_lane_o[0]));
        report_count++;
      end else begin
        want = expected_sums.pop_front();
        for (int j = 0; j < IN_LANES; j++)
          if (result_lane_o[j] !== want.lanes[j])
            report_mismatch($sformatf("result_lane_%0d", j), $signed(want.lanes[j]),
                            $signed(result_lane_o[j]));
        if (last_chunk_o !== want.last) report_mismatch("last_chunk", want.last, last_chunk_o);
      end
    end
  end

  // stimulus sequence
  initial begin
    logic [SHIFT_W-1:0] shifts [6];
    for (int i = 0; i < VECTOR_LENGTH; i++) acc_image[i] = '0;
    shifts = '{5'd31, 5'($urandom_range(31)), 5'd0, SHIFT_RESET, 5'($urandom_range(31)), 5'd7};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    // accumulator clearing sweep after reset
    while (in_stall_o !== 1'b0) @(posedge clk);

    write_shift(5'd0);
    queue_directed();
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 7;
          recv_stall_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_stall_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      write_shift(shifts[p]);
      if (p == 4) pressure_armed = 1'b1;
      queue_phase(PHASE_ITEMS);
      wait_drained();
    end

    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
